FILE: src/qvr_pkg.sv
// Shared widths and control types for the quaternion vector rotation pipeline.
// No dependencies.
package qvr_pkg;

  localparam int QUAT_W = 16;  // quaternion part width
  localparam int PROD_W = 32;  // 16x16 product
  localparam int M_W    = 35;  // rotation matrix entry, scaled by |q|^2
  localparam int N_W    = 33;  // |q|^2
  localparam int D_W    = 34;  // divisor 2*|q|^2
  localparam int REM_W  = 35;  // partial remainder
  localparam int LANES  = 3;
  localparam int MENT   = 9;

  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

endpackage

FILE: src/qvr_matrix.sv
// Two stages: quaternion products, then the scaled rotation matrix and |q|^2.
// Uses qvr_pkg.
module qvr_matrix import qvr_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic signed [QUAT_W-1:0] qx,
  input  logic signed [QUAT_W-1:0] qy,
  input  logic signed [QUAT_W-1:0] qz,
  input  logic signed [QUAT_W-1:0] qw,
  input  logic signed [CW-1:0]     vin [LANES],
  output ctl_t                     ctl_o,
  output logic signed [M_W-1:0]    m_o [MENT],
  output logic [N_W-1:0]           n_o,
  output logic signed [CW-1:0]     v_o [LANES]
);

  logic signed [PROD_W-1:0] x2_r, y2_r, z2_r, w2_r;
  logic signed [PROD_W-1:0] xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic signed [CW-1:0]     v1_r [LANES];
  logic                     vld1_r;
  logic [N_W-1:0]           n_nxt;
  logic signed [M_W-1:0]    m_nxt [MENT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r <= qx * qx;
      y2_r <= qy * qy;
      z2_r <= qz * qz;
      w2_r <= qw * qw;
      xy_r <= qx * qy;
      wz_r <= qw * qz;
      xz_r <= qx * qz;
      wy_r <= qw * qy;
      yz_r <= qy * qz;
      wx_r <= qw * qx;
      v1_r <= vin;
    end
  end

  always_comb begin
    n_nxt = N_W'($unsigned(x2_r)) + N_W'($unsigned(y2_r)) +
            N_W'($unsigned(z2_r)) + N_W'($unsigned(w2_r));
    m_nxt[0] = M_W'(w2_r) + M_W'(x2_r) - M_W'(y2_r) - M_W'(z2_r);
    m_nxt[1] = (M_W'(xy_r) - M_W'(wz_r)) <<< 1;
    m_nxt[2] = (M_W'(xz_r) + M_W'(wy_r)) <<< 1;
    m_nxt[3] = (M_W'(xy_r) + M_W'(wz_r)) <<< 1;
    m_nxt[4] = M_W'(w2_r) - M_W'(x2_r) + M_W'(y2_r) - M_W'(z2_r);
    m_nxt[5] = (M_W'(yz_r) - M_W'(wx_r)) <<< 1;
    m_nxt[6] = (M_W'(xz_r) - M_W'(wy_r)) <<< 1;
    m_nxt[7] = (M_W'(yz_r) + M_W'(wx_r)) <<< 1;
    m_nxt[8] = M_W'(w2_r) - M_W'(x2_r) - M_W'(y2_r) + M_W'(z2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.vld <= 1'b0;
    end else if (en) begin
      ctl_o.vld <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o.zero <= (n_nxt == '0);
      m_o        <= m_nxt;
      n_o        <= n_nxt;
      v_o        <= v1_r;
    end
  end

endmodule

FILE: src/qvr_dot.sv
// Two stages: matrix-vector products, then row sums biased for rounding.
// Uses qvr_pkg.
module qvr_dot import qvr_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  ctl_t                     ctl_i,
  input  logic signed [M_W-1:0]    m_i [MENT],
  input  logic [N_W-1:0]           n_i,
  input  logic signed [CW-1:0]     v_i [LANES],
  output ctl_t                     ctl_o,
  output logic                     sign_o [LANES],
  output logic [M_W+CW+3:0]        mag_o [LANES],
  output logic [D_W-1:0]           d_o
);

  localparam int PW = M_W + CW;
  localparam int SW = PW + 2;
  localparam int AW = PW + 4;

  logic signed [PW-1:0] p_r [MENT];
  logic [N_W-1:0]       n1_r;
  ctl_t                 ctl1_r;
  logic signed [SW-1:0] sum [LANES];
  logic signed [AW-1:0] num [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.vld <= 1'b0;
      ctl_o.vld  <= 1'b0;
    end else if (en) begin
      ctl1_r.vld <= ctl_i.vld;
      ctl_o.vld  <= ctl1_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MENT; k++) begin
        p_r[k] <= PW'(m_i[k]) * PW'(v_i[k % LANES]);
      end
      n1_r        <= n_i;
      ctl1_r.zero <= ctl_i.zero;
    end
  end

  // floor((2*Mv + n) / 2n) gives round-half-up of Mv / n
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum[i] = SW'(p_r[LANES*i]) + SW'(p_r[LANES*i+1]) + SW'(p_r[LANES*i+2]);
      num[i] = (AW'(sum[i]) <<< 1) + AW'($signed({1'b0, n1_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        sign_o[i] <= num[i][AW-1];
        mag_o[i]  <= num[i][AW-1] ? AW'(-num[i]) : AW'(num[i]);
      end
      d_o        <= {n1_r, 1'b0};
      ctl_o.zero <= ctl1_r.zero;
    end
  end

endmodule

FILE: src/qvr_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor. Uses qvr_pkg.
module qvr_div import qvr_pkg::*; #(
  parameter int CW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ctl_t              ctl_i,
  input  logic              sign_i [LANES],
  input  logic [M_W+CW+3:0] mag_i [LANES],
  input  logic [D_W-1:0]    d_i,
  output ctl_t              ctl_o,
  output logic              sign_o [LANES],
  output logic [CW+1:0]     q_o [LANES],
  output logic              rnz_o [LANES]
);

  localparam int AW = M_W + CW + 4;
  localparam int QB = CW + 2;

  ctl_t             ctl_r  [QB+1];
  logic [D_W-1:0]   d_r    [QB+1];
  logic             sgn_r  [QB+1][LANES];
  logic [REM_W-1:0] rem_r  [QB+1][LANES];
  logic [QB-1:0]    lo_r   [QB+1][LANES];
  logic [QB-1:0]    q_r    [QB+1][LANES];

  // quotient fits QB bits, so the top part of the dividend is already below d
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].vld <= 1'b0;
    end else if (en) begin
      ctl_r[0].vld <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0].zero <= ctl_i.zero;
      d_r[0]        <= d_i;
      for (int l = 0; l < LANES; l++) begin
        sgn_r[0][l] <= sign_i[l];
        rem_r[0][l] <= REM_W'(mag_i[l] >> QB);
        lo_r[0][l]  <= mag_i[l][QB-1:0];
        q_r[0][l]   <= '0;
      end
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [REM_W-1:0] t  [LANES];
    logic             ge [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]  = {rem_r[s-1][l][REM_W-2:0], lo_r[s-1][l][QB-1]};
        ge[l] = (t[l] >= REM_W'(d_r[s-1]));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s].vld <= 1'b0;
      end else if (en) begin
        ctl_r[s].vld <= ctl_r[s-1].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[s].zero <= ctl_r[s-1].zero;
        d_r[s]        <= d_r[s-1];
        for (int l = 0; l < LANES; l++) begin
          sgn_r[s][l] <= sgn_r[s-1][l];
          rem_r[s][l] <= ge[l] ? t[l] - REM_W'(d_r[s-1]) : t[l];
          lo_r[s][l]  <= {lo_r[s-1][l][QB-2:0], 1'b0};
          q_r[s][l]   <= {q_r[s-1][l][QB-2:0], ge[l]};
        end
      end
    end
  end

  always_comb begin
    ctl_o = ctl_r[QB];
    for (int l = 0; l < LANES; l++) begin
      sign_o[l] = sgn_r[QB][l];
      q_o[l]    = q_r[QB][l];
      rnz_o[l]  = |rem_r[QB][l];
    end
  end

endmodule

FILE: src/quaternion_vector_rotate.sv
// Top level: rotates a vector by a quaternion, computing q v q* / |q|^2.
// Uses qvr_pkg, qvr_matrix, qvr_dot, qvr_div.
//
//  channel | ports                                   | direction
//  in      | in_valid, in_stall, in_quat_*, in_vec_* | vector and quaternion in
//  out     | out_valid, out_stall, out_rot_*, out_zero_quat | rotated vector out
//
// One transaction per cycle unless a stalled output holds the pipeline. Stages: 2 product,
// 2 dot, 1 divider load, CW+2 quotient-bit stages, 1 output; the divider is the deepest.
// rst_n clears all valid bits; data registers are not reset.
// A stalled output freezes the whole pipeline; in_stall follows it.
module quaternion_vector_rotate import qvr_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [QUAT_W-1:0]     in_quat_x,
  input  logic signed [QUAT_W-1:0]     in_quat_y,
  input  logic signed [QUAT_W-1:0]     in_quat_z,
  input  logic signed [QUAT_W-1:0]     in_quat_w,
  input  logic signed [COORD_WIDTH-1:0] in_vec_x,
  input  logic signed [COORD_WIDTH-1:0] in_vec_y,
  input  logic signed [COORD_WIDTH-1:0] in_vec_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_WIDTH:0]  out_rot_x,
  output logic signed [COORD_WIDTH:0]  out_rot_y,
  output logic signed [COORD_WIDTH:0]  out_rot_z,
  output logic                         out_zero_quat
);

  localparam int CW   = COORD_WIDTH;
  localparam int QB   = CW + 2;
  localparam int RESW = QB + 1;
  localparam logic signed [RESW-1:0] SAT_MAX = {{(RESW-CW){1'b0}}, {CW{1'b1}}};
  localparam logic signed [RESW-1:0] SAT_MIN = ~SAT_MAX;

  logic                  en;
  logic signed [CW-1:0]  vin [LANES];
  ctl_t                  mat_ctl, dot_ctl, div_ctl;
  logic signed [M_W-1:0] mat_m [MENT];
  logic [N_W-1:0]        mat_n;
  logic signed [CW-1:0]  mat_v [LANES];
  logic                  dot_sign [LANES];
  logic [M_W+CW+3:0]     dot_mag [LANES];
  logic [D_W-1:0]        dot_d;
  logic                  div_sign [LANES];
  logic [QB-1:0]         div_q [LANES];
  logic                  div_rnz [LANES];
  logic signed [RESW-1:0] res [LANES];
  logic signed [CW:0]     rot_nxt [LANES];
  logic                  out_valid_r;
  logic signed [CW:0]    rot_r [LANES];
  logic                  zero_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign vin[0]   = in_vec_x;
  assign vin[1]   = in_vec_y;
  assign vin[2]   = in_vec_z;

  qvr_matrix #(.CW(CW)) u_matrix (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .qx(in_quat_x), .qy(in_quat_y), .qz(in_quat_z), .qw(in_quat_w),
    .vin(vin), .ctl_o(mat_ctl), .m_o(mat_m), .n_o(mat_n), .v_o(mat_v)
  );

  qvr_dot #(.CW(CW)) u_dot (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(mat_ctl), .m_i(mat_m),
    .n_i(mat_n), .v_i(mat_v), .ctl_o(dot_ctl), .sign_o(dot_sign),
    .mag_o(dot_mag), .d_o(dot_d)
  );

  qvr_div #(.CW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(dot_ctl), .sign_i(dot_sign),
    .mag_i(dot_mag), .d_i(dot_d), .ctl_o(div_ctl), .sign_o(div_sign),
    .q_o(div_q), .rnz_o(div_rnz)
  );

  // floor of a negative quotient: -(q + 1) when the remainder is nonzero
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      res[l] = div_sign[l] ? -$signed({1'b0, div_q[l]}) - RESW'(div_rnz[l])
                           : $signed({1'b0, div_q[l]});
      if (div_ctl.zero) begin
        rot_nxt[l] = '0;
      end else if (res[l] > SAT_MAX) begin
        rot_nxt[l] = SAT_MAX[CW:0];
      end else if (res[l] < SAT_MIN) begin
        rot_nxt[l] = SAT_MIN[CW:0];
      end else begin
        rot_nxt[l] = res[l][CW:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r  <= rot_nxt;
      zero_r <= div_ctl.zero;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rot_x     = rot_r[0];
  assign out_rot_y     = rot_r[1];
  assign out_rot_z     = rot_r[2];
  assign out_zero_quat = zero_r;

`ifndef SYNTHESIS
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_quat |-> out_rot_x == '0 && out_rot_y == '0 && out_rot_z == '0)
    else $error("zero quaternion result not cleared");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rot_x) && $stable(out_zero_quat))
    else $error("stalled result changed");
`endif

endmodule
